@@ rtl/fixed_pattern_noise_calibrator_defines.svh @@
// assertion helpers used by the calibrator rtl
`ifndef FIXED_PATTERN_NOISE_CALIBRATOR_DEFINES_SVH
`define FIXED_PATTERN_NOISE_CALIBRATOR_DEFINES_SVH

// same-cycle implication
`define FPNC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPNC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpnc_pkg.sv @@
`default_nettype none
package fpnc_pkg;

  localparam int IDX_W     = 14;
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 16;
  localparam int FRAME_W   = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [PIX_W-1:0]   PIX_MAX          = 8'd255;
  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 15'd12544;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_ENABLE = 1'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ACCUM   = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_CORRECT = 2'd3
  } cmd_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] value;
    logic             is_finish;
  } fpnc_res_t;

endpackage
`default_nettype wire

@@ rtl/fpnc_ram.sv @@
`default_nettype none
module fpnc_ram #(
  parameter int   WIDTH  = 8,
  parameter int   DEPTH  = 16384,
  localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [ADDR_W-1:0]         rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/fpnc_ctrl.sv @@
`default_nettype none
`include "fixed_pattern_noise_calibrator_defines.svh"
module fpnc_ctrl #(
  parameter int  MAX_PIXELS = 16384,
  parameter int  AVG_SHIFT  = 7,
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fpnc_pkg::cmd_t                cmd,
  input  wire logic [fpnc_pkg::IDX_W-1:0]    pixel_index,
  input  wire logic [fpnc_pkg::PIX_W-1:0]    pixel_value,
  input  wire logic [fpnc_pkg::FRAME_W-1:0]  frame_pixels,
  input  wire logic                          correction_enable,
  output fpnc_pkg::fpnc_res_t                res,
  input  wire logic                          res_ready,
  output logic                               sum_rd_en,
  output logic      [ADDR_W-1:0]             sum_rd_addr,
  input  wire logic [fpnc_pkg::SUM_W-1:0]    sum_rd_data,
  output logic                               sum_wr_en,
  output logic      [ADDR_W-1:0]             sum_wr_addr,
  output logic      [fpnc_pkg::SUM_W-1:0]    sum_wr_data,
  output logic                               mask_rd_en,
  output logic      [ADDR_W-1:0]             mask_rd_addr,
  input  wire logic [fpnc_pkg::PIX_W-1:0]    mask_rd_data,
  output logic                               mask_wr_en,
  output logic      [ADDR_W-1:0]             mask_wr_addr,
  output logic      [fpnc_pkg::PIX_W-1:0]    mask_wr_data
);
  import fpnc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int NW     = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
  localparam logic [NW-1:0]    MAXP     = NW'(MAX_PIXELS);
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(MAX_PIXELS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ACC, S_MAX, S_MASK, S_CORR, S_RESULT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  k;
  logic [ADDR_W-1:0] k_d;
  logic              pend;
  logic [PIX_W-1:0]  max_avg;
  logic [ADDR_W-1:0] idx_r;
  logic [PIX_W-1:0]  val_r;
  logic              use_mask_r;
  logic [PIX_W-1:0]  res_value;
  logic              res_finish;

  logic [NW-1:0]     frame_ext;
  logic [NW-1:0]     n_act;
  logic [NW-1:0]     idx_ext;
  logic [ADDR_W-1:0] idx_addr;
  logic              in_range;
  logic              in_accept;
  logic              issue;
  logic [SUM_W-1:0]  avg_wide;
  logic [PIX_W-1:0]  avg;

  // active pixel count, clipped to the memory depth
  assign frame_ext = NW'(frame_pixels);
  assign n_act     = (frame_ext < MAXP) ? frame_ext : MAXP;
  assign idx_ext   = NW'(pixel_index);
  assign idx_addr  = idx_ext[ADDR_W-1:0];
  assign in_range  = idx_ext < n_act;

  assign in_ready  = (state == S_IDLE) || ((state == S_RESULT) && res_ready);
  assign in_accept = in_valid && in_ready;

  // scan reads during both finish passes
  assign issue = ((state == S_MAX) || (state == S_MASK)) && (NW'(k) < n_act);

  assign avg_wide = sum_rd_data >> AVG_SHIFT;
  assign avg      = (|avg_wide[SUM_W-1:PIX_W]) ? PIX_MAX : avg_wide[PIX_W-1:0];

  assign sum_rd_en   = issue || (in_accept && (cmd == CMD_ACCUM) && in_range);
  assign sum_rd_addr = issue ? k[ADDR_W-1:0] : idx_addr;
  assign sum_wr_en   = (state == S_CLEAR) || (state == S_ACC);
  assign sum_wr_addr = (state == S_CLEAR) ? k[ADDR_W-1:0] : idx_r;
  assign sum_wr_data = (state == S_CLEAR) ? '0 : sum_rd_data + SUM_W'(val_r);

  assign mask_rd_en   = in_accept && (cmd == CMD_CORRECT) && in_range && correction_enable;
  assign mask_rd_addr = idx_addr;
  assign mask_wr_en   = (state == S_MASK) && pend;
  assign mask_wr_addr = k_d;
  assign mask_wr_data = max_avg - avg;

  assign res.valid     = (state == S_RESULT);
  assign res.value     = res_value;
  assign res.is_finish = res_finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      max_avg <= '0;
    end else begin
      pend <= issue;
      k_d  <= k[ADDR_W-1:0];
      if (in_accept) begin
        idx_r      <= idx_addr;
        val_r      <= pixel_value;
        use_mask_r <= in_range && correction_enable;
        unique case (cmd)
          CMD_CLEAR: begin
            k     <= '0;
            state <= S_CLEAR;
          end
          CMD_ACCUM: begin
            state <= in_range ? S_ACC : S_IDLE;
          end
          CMD_FINISH: begin
            k       <= '0;
            max_avg <= '0;
            if (n_act == '0) begin
              res_value  <= '0;
              res_finish <= 1'b1;
              state      <= S_RESULT;
            end else begin
              state <= S_MAX;
            end
          end
          CMD_CORRECT: begin
            state <= S_CORR;
          end
          default: state <= S_IDLE;
        endcase
      end else begin
        unique case (state)
          S_IDLE: ;
          S_CLEAR: begin
            k <= k + 1'b1;
            if (k == LAST_ROW) begin
              state <= S_IDLE;
            end
          end
          S_ACC: state <= S_IDLE;
          S_MAX: begin
            if (issue) begin
              k <= k + 1'b1;
            end
            if (pend && (avg > max_avg)) begin
              max_avg <= avg;
            end
            if (!issue && !pend) begin
              k     <= '0;
              state <= S_MASK;
            end
          end
          S_MASK: begin
            if (issue) begin
              k <= k + 1'b1;
            end
            if (!issue && !pend) begin
              res_value  <= max_avg;
              res_finish <= 1'b1;
              state      <= S_RESULT;
            end
          end
          S_CORR: begin
            res_value  <= use_mask_r ? val_r + mask_rd_data : val_r;
            res_finish <= 1'b0;
            state      <= S_RESULT;
          end
          S_RESULT: begin
            if (res_ready) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `FPNC_ASSERT_IMP(a_acc_after_read, clk, rst, state == S_ACC, $past(sum_rd_en), "accumulate write without read")
  `FPNC_ASSERT_IMP(a_no_rw_overlap, clk, rst, sum_wr_en, !sum_rd_en, "sum read overlaps a write")
  `FPNC_ASSERT_IMP(a_mask_in_frame, clk, rst, mask_wr_en, NW'(k_d) < n_act, "mask write beyond frame")
  `FPNC_ASSERT_NXT(a_clear_blocks, clk, rst, in_accept && (cmd == CMD_CLEAR), !in_ready, "input taken during clear")
endmodule
`default_nettype wire

@@ rtl/fixed_pattern_noise_calibrator.sv @@
// fixed pattern noise calibrator
// input channel (in_valid / in_ready) carries one command word: cmd, pixel_index,
// pixel_value. clear zeroes every per-pixel sum, accumulate adds a sample into
// its pixel's 16-bit sum, finish builds the mask and reports the maximum average,
// correct adds the stored mask to a sample
// output channel (out_valid / out_ready) carries value_out and is_finish; only
// finish and correct produce a word
// one command is worked on at a time; all per-pixel state sits in two rams,
// each with one write port and one registered read port:
//   accumulate  sum read, then write back
//   correct     mask read, then add, into the output register
//   clear       all MAX_PIXELS sum rows, one row written per cycle
//   finish      a maximum pass over the n active pixels, then a
//               mask pass, each one sum read per cycle
// the output register lets the next command be taken while a word waits; a
// stalled receiver holds the following result inside the sequencer, and input
// is refused until it drains
// reset sets frame_pixels to 12544, enables correction and clears the maximum;
// sums stay undefined until a clear, masks until a finish; cfg_we writes
// (index 0 frame_pixels, index 1 correction_enable) take effect at once
`default_nettype none
module fixed_pattern_noise_calibrator #(
  parameter int MAX_PIXELS = 16384,
  parameter int AVG_SHIFT  = 7
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       cmd,
  input  wire logic [fpnc_pkg::IDX_W-1:0]       pixel_index,
  input  wire logic [fpnc_pkg::PIX_W-1:0]       pixel_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [fpnc_pkg::PIX_W-1:0]       value_out,
  output logic                                  is_finish,
  input  wire logic                             cfg_we,
  input  wire logic [fpnc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpnc_pkg::FRAME_W-1:0]     cfg_wdata
);
  import fpnc_pkg::*;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  // configuration registers
  logic [FRAME_W-1:0] frame_pixels;
  logic               correction_enable;

  // sequencer to output register
  fpnc_res_t res;
  logic      res_ready;

  // ram ports
  logic              sum_rd_en;
  logic [ADDR_W-1:0] sum_rd_addr;
  logic [SUM_W-1:0]  sum_rd_data;
  logic              sum_wr_en;
  logic [ADDR_W-1:0] sum_wr_addr;
  logic [SUM_W-1:0]  sum_wr_data;
  logic              mask_rd_en;
  logic [ADDR_W-1:0] mask_rd_addr;
  logic [PIX_W-1:0]  mask_rd_data;
  logic              mask_wr_en;
  logic [ADDR_W-1:0] mask_wr_addr;
  logic [PIX_W-1:0]  mask_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels      <= FRAME_PIXELS_RST;
      correction_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_PIXELS:      frame_pixels      <= cfg_wdata;
        REG_CORRECTION_ENABLE: correction_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output register: loads whenever it is empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
      if (res.valid) begin
        value_out <= res.value;
        is_finish <= res.is_finish;
      end
    end
  end

  fpnc_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .AVG_SHIFT  (AVG_SHIFT)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd_t'(cmd)),
    .pixel_index       (pixel_index),
    .pixel_value       (pixel_value),
    .frame_pixels      (frame_pixels),
    .correction_enable (correction_enable),
    .res               (res),
    .res_ready         (res_ready),
    .sum_rd_en         (sum_rd_en),
    .sum_rd_addr       (sum_rd_addr),
    .sum_rd_data       (sum_rd_data),
    .sum_wr_en         (sum_wr_en),
    .sum_wr_addr       (sum_wr_addr),
    .sum_wr_data       (sum_wr_data),
    .mask_rd_en        (mask_rd_en),
    .mask_rd_addr      (mask_rd_addr),
    .mask_rd_data      (mask_rd_data),
    .mask_wr_en        (mask_wr_en),
    .mask_wr_addr      (mask_wr_addr),
    .mask_wr_data      (mask_wr_data)
  );

  // per-pixel wrapping sums
  fpnc_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PIXELS)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (sum_wr_en),
    .wr_addr (sum_wr_addr),
    .wr_data (sum_wr_data),
    .rd_en   (sum_rd_en),
    .rd_addr (sum_rd_addr),
    .rd_data (sum_rd_data)
  );

  // per-pixel correction mask
  fpnc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (mask_wr_en),
    .wr_addr (mask_wr_addr),
    .wr_data (mask_wr_data),
    .rd_en   (mask_rd_en),
    .rd_addr (mask_rd_addr),
    .rd_data (mask_rd_data)
  );
endmodule
`default_nettype wire
